FILE: rtl/greedy_note_dispenser_macros.svh
// Assertion shorthands shared by the dispenser modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef GREEDY_NOTE_DISPENSER_MACROS_SVH
`define GREEDY_NOTE_DISPENSER_MACROS_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define GND_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The expression is never true.
`define GND_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: rtl/gnd_pkg.sv
package gnd_pkg;

    // Fixed field widths of the request and response words.
    localparam int SLOT_W       = 3;
    localparam int NOTE_COUNT_W = 16;
    localparam int AMOUNT_IN_W  = 24;
    localparam int TAKE_W       = 16;

    // Defaults for the top-level parameters.
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int AMOUNT_WIDTH_DEF = 24;

    // Note slots, indexed like the slot field: value 1 in slot 0 up to 100 in slot 6.
    localparam int NUM_SLOTS    = 7;
    localparam int NOTE_VALUE_W = 7;
    localparam int unsigned NOTE_VALUE [NUM_SLOTS] = '{1, 2, 5, 10, 20, 50, 100};

    // Function codes of a request word.
    localparam logic FUNC_STOCK    = 1'b0;
    localparam logic FUNC_WITHDRAW = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [SLOT_W-1:0]       slot;
        logic [NOTE_COUNT_W-1:0] note_count;
        logic [AMOUNT_IN_W-1:0]  amount;
    } req_word_t;

    typedef struct packed {
        logic              accepted;
        logic [TAKE_W-1:0] take_hundred;
        logic [TAKE_W-1:0] take_fifty;
        logic [TAKE_W-1:0] take_twenty;
        logic [TAKE_W-1:0] take_ten;
        logic [TAKE_W-1:0] take_five;
        logic [TAKE_W-1:0] take_two;
        logic [TAKE_W-1:0] take_one;
    } rsp_word_t;

    // Commands broadcast from the controller to every cell.
    typedef struct packed {
        logic                    stock_en;
        logic [SLOT_W-1:0]       slot;
        logic [NOTE_COUNT_W-1:0] note_count;
        logic                    commit;
    } cell_ctl_t;

endpackage

FILE: rtl/greedy_note_dispenser.sv
// Cash note dispenser with seven slots (notes of 100, 50, 20, 10, 5, 2 and 1).
// A stock word adds notes to one slot, saturating at the count limit; a withdraw
// word pays the amount greedily from the largest note down and is accepted only
// if it is paid in full, in which case the stock is reduced. Every request word
// gives one response word. The slots form a row of cells through which the
// remaining amount walks from the 100 cell to the 1 cell. Each cell either pays its
// whole stock or nothing after a single test, or, when it must divide, runs a long
// division of the amount, one byte a cycle. One request is in work at a time; a
// new request is taken while the previous response still waits to be read, and
// a finished request waits until the response register is free.
`include "greedy_note_dispenser_macros.svh"

module greedy_note_dispenser #(
    parameter int COUNT_WIDTH  = gnd_pkg::COUNT_WIDTH_DEF,
    parameter int AMOUNT_WIDTH = gnd_pkg::AMOUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  gnd_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output gnd_pkg::rsp_word_t rsp
);
    import gnd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                  state_reg;
    logic                    start_reg;
    logic [AMOUNT_WIDTH-1:0] amount_reg;
    logic                    func_reg;
    logic                    acc_reg;
    cell_ctl_t               ctl_reg;
    logic                    rsp_valid_reg;
    rsp_word_t               rsp_reg;

    logic [NUM_SLOTS:0]      tok_bus;
    logic [AMOUNT_WIDTH-1:0] rest_bus [NUM_SLOTS+1];
    logic [TAKE_W-1:0]       take_bus [NUM_SLOTS];

    logic                    pay;
    logic                    rsp_free;
    logic                    rest_zero;
    rsp_word_t               rsp_load;

    // Row of slot cells; the amount enters at the largest note.
    assign tok_bus[NUM_SLOTS]  = start_reg;
    assign rest_bus[NUM_SLOTS] = amount_reg;

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        gnd_cell #(
            .COUNT_WIDTH  (COUNT_WIDTH),
            .AMOUNT_WIDTH (AMOUNT_WIDTH),
            .SLOT_INDEX   (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl_reg),
            .tok_in   (tok_bus[i+1]),
            .rest_in  (rest_bus[i+1]),
            .tok_out  (tok_bus[i]),
            .rest_out (rest_bus[i]),
            .take     (take_bus[i])
        );
    end

    // Response word: take counts only on a withdrawal that was paid in full.
    assign pay       = acc_reg && (func_reg == FUNC_WITHDRAW);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rest_zero = (rest_bus[0] == '0);

    always_comb
    begin
        rsp_load.accepted     = acc_reg;
        rsp_load.take_hundred = pay ? take_bus[6] : '0;
        rsp_load.take_fifty   = pay ? take_bus[5] : '0;
        rsp_load.take_twenty  = pay ? take_bus[4] : '0;
        rsp_load.take_ten     = pay ? take_bus[3] : '0;
        rsp_load.take_five    = pay ? take_bus[2] : '0;
        rsp_load.take_two     = pay ? take_bus[1] : '0;
        rsp_load.take_one     = pay ? take_bus[0] : '0;
    end

    // Request sequencing, cell commands and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            amount_reg    <= '0;
            func_reg      <= FUNC_STOCK;
            acc_reg       <= 1'b0;
            ctl_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            start_reg        <= 1'b0;
            ctl_reg.stock_en <= 1'b0;
            ctl_reg.commit   <= 1'b0;

            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        func_reg <= req.func;
                        if (req.func == FUNC_STOCK)
                        begin
                            // A slot code past the last slot is ignored.
                            ctl_reg.stock_en   <= 1'b1;
                            ctl_reg.slot       <= req.slot;
                            ctl_reg.note_count <= req.note_count;
                            acc_reg            <= (req.slot < SLOT_W'(NUM_SLOTS));
                            state_reg          <= S_FINISH;
                        end
                        else
                        begin
                            amount_reg <= AMOUNT_WIDTH'(req.amount);
                            start_reg  <= 1'b1;
                            state_reg  <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    // The smallest cell is done: paid in full only if nothing is left.
                    if (tok_bus[0])
                    begin
                        acc_reg        <= rest_zero;
                        ctl_reg.commit <= rest_zero;
                        state_reg      <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg       <= rsp_load;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `GND_ASSERT_NEVER(a_ctl_exclusive, ctl_reg.stock_en && ctl_reg.commit, "stock with commit")
    `GND_ASSERT_IMPLY(a_tok_in_walk, tok_bus[0], state_reg == S_WALK, "token outside a walk")
    `GND_ASSERT_IMPLY(a_commit_walk, ctl_reg.commit, $past(state_reg) == S_WALK, "stray commit")

endmodule

FILE: rtl/gnd_cell.sv
`include "greedy_note_dispenser_macros.svh"

// One note slot: holds its stock count and, when the remaining amount passes
// through, works out how many of its notes to pay and hands the rest on.
module gnd_cell #(
    parameter int COUNT_WIDTH  = gnd_pkg::COUNT_WIDTH_DEF,
    parameter int AMOUNT_WIDTH = gnd_pkg::AMOUNT_WIDTH_DEF,
    parameter int SLOT_INDEX   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gnd_pkg::cell_ctl_t            ctl,
    input  logic                          tok_in,
    input  logic [AMOUNT_WIDTH-1:0]       rest_in,
    output logic                          tok_out,
    output logic [AMOUNT_WIDTH-1:0]       rest_out,
    output logic [gnd_pkg::TAKE_W-1:0]    take
);
    import gnd_pkg::*;

    localparam int NoteValue  = NOTE_VALUE[SLOT_INDEX];
    localparam int ProdWidth  = COUNT_WIDTH + NOTE_VALUE_W;
    localparam int CmpWidth   = (AMOUNT_WIDTH > ProdWidth) ? AMOUNT_WIDTH : ProdWidth;
    localparam int SumWidth   = ((COUNT_WIDTH > NOTE_COUNT_W) ? COUNT_WIDTH : NOTE_COUNT_W) + 1;
    // Long division takes the amount one digit a cycle, most significant first.
    localparam int DigitW     = 8;
    localparam int NumDigits  = (AMOUNT_WIDTH + DigitW - 1) / DigitW;
    localparam int NumWidth   = NumDigits * DigitW;
    localparam int DigCntW    = (NumDigits > 1) ? $clog2(NumDigits) : 1;
    // A partial dividend is the running remainder (below the note value) and one digit.
    localparam int PartWidth  = NOTE_VALUE_W + DigitW;
    localparam int RecipShift = PartWidth + NOTE_VALUE_W;
    localparam int RecipWidth = RecipShift + 1;
    localparam int PartProdW  = PartWidth + RecipWidth;
    localparam longint unsigned RecipFull =
        ((64'd1 << RecipShift) + 64'(NoteValue) - 64'd1) / 64'(NoteValue);
    localparam logic [RecipWidth-1:0]  Recip    = RecipWidth'(RecipFull);
    localparam logic [SLOT_W-1:0]      SlotCode = SLOT_W'(SLOT_INDEX);
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    typedef enum logic [1:0] {
        C_IDLE,
        C_TEST,
        C_DIV
    } cell_state_t;

    cell_state_t              state_reg;
    logic [COUNT_WIDTH-1:0]   stock_reg;
    logic [ProdWidth-1:0]     prod_reg;
    logic [COUNT_WIDTH-1:0]   take_reg;
    logic [AMOUNT_WIDTH-1:0]  rest_reg;
    logic [NumWidth-1:0]      num_reg;
    logic [DigCntW-1:0]       dig_reg;
    logic                     tok_out_reg;

    logic [SumWidth-1:0]      stock_sum;
    logic [COUNT_WIDTH-1:0]   stock_sat;
    logic [CmpWidth-1:0]      rest_wide;
    logic                     covers_all;
    logic                     below_note;
    logic                     took_all;
    logic [DigitW-1:0]        dig_val;
    logic [PartWidth-1:0]     part_val;
    logic [PartProdW-1:0]     part_prod;
    logic [DigitW-1:0]        q_dig;
    logic [PartWidth-1:0]     r_dig;
    logic [COUNT_WIDTH-1:0]   quo_next;

    // Saturating add for a stock word.
    assign stock_sum = SumWidth'(stock_reg) + SumWidth'(ctl.note_count);
    assign stock_sat = (stock_sum > SumWidth'(CountMax)) ? CountMax
                                                         : stock_sum[COUNT_WIDTH-1:0];

    // Compares of the remaining amount against the whole stock and one note.
    assign rest_wide  = CmpWidth'(rest_reg);
    assign covers_all = rest_wide >= CmpWidth'(prod_reg);
    assign below_note = rest_wide < CmpWidth'(NoteValue);
    assign took_all   = (take_reg == stock_reg);

    // One division step: the digit quotient comes from a multiply by the scaled
    // reciprocal of the note value, which is exact over the partial dividend range.
    assign dig_val   = num_reg[NumWidth-1 -: DigitW];
    assign part_val  = {rest_reg[NOTE_VALUE_W-1:0], dig_val};
    assign part_prod = PartProdW'(part_val) * PartProdW'(Recip);
    assign q_dig     = part_prod[RecipShift +: DigitW];
    assign r_dig     = part_val - PartWidth'(q_dig) * PartWidth'(NoteValue);
    assign quo_next  = COUNT_WIDTH'({take_reg, q_dig});

    // Stock bookkeeping and the per-slot payout sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            stock_reg   <= '0;
            prod_reg    <= '0;
            take_reg    <= '0;
            rest_reg    <= '0;
            num_reg     <= '0;
            dig_reg     <= '0;
            tok_out_reg <= 1'b0;
        end
        else
        begin
            tok_out_reg <= 1'b0;
            // Value of the whole stock; stock does not move while an amount walks.
            prod_reg    <= ProdWidth'(stock_reg) * ProdWidth'(NoteValue);

            if (ctl.stock_en && ctl.slot == SlotCode)
            begin
                stock_reg <= stock_sat;
            end
            else if (ctl.commit)
            begin
                stock_reg <= stock_reg - take_reg;
            end

            unique case (state_reg)
                C_IDLE:
                begin
                    if (tok_in)
                    begin
                        rest_reg  <= rest_in;
                        state_reg <= C_TEST;
                    end
                end
                C_TEST:
                begin
                    priority if (covers_all)
                    begin
                        // The amount covers every note on hand.
                        take_reg    <= stock_reg;
                        rest_reg    <= rest_reg - AMOUNT_WIDTH'(prod_reg);
                        tok_out_reg <= 1'b1;
                        state_reg   <= C_IDLE;
                    end
                    else if (below_note)
                    begin
                        take_reg    <= '0;
                        tok_out_reg <= 1'b1;
                        state_reg   <= C_IDLE;
                    end
                    else
                    begin
                        // Quotient is below the stock: divide, the rest register
                        // carrying the running remainder.
                        take_reg  <= '0;
                        num_reg   <= NumWidth'(rest_reg);
                        rest_reg  <= '0;
                        dig_reg   <= DigCntW'(NumDigits - 1);
                        state_reg <= C_DIV;
                    end
                end
                C_DIV:
                begin
                    take_reg <= quo_next;
                    rest_reg <= AMOUNT_WIDTH'(r_dig[NOTE_VALUE_W-1:0]);
                    num_reg  <= num_reg << DigitW;
                    if (dig_reg == '0)
                    begin
                        tok_out_reg <= 1'b1;
                        state_reg   <= C_IDLE;
                    end
                    else
                    begin
                        dig_reg <= dig_reg - DigCntW'(1);
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign tok_out  = tok_out_reg;
    assign rest_out = rest_reg;
    assign take     = TAKE_W'(take_reg);

    `GND_ASSERT_IMPLY(a_take_le_stock, tok_out_reg, take_reg <= stock_reg, "take above stock")
    `GND_ASSERT_IMPLY(a_greedy_rest, tok_out_reg && !took_all, below_note, "payable rest left")
    `GND_ASSERT_NEVER(a_tok_while_busy, tok_in && state_reg != C_IDLE, "amount arrives while busy")

endmodule

FILE: bench/gnd_payout_checker.sv
`timescale 1ns / 1ps

module gnd_payout_checker #(
    parameter int COUNT_WIDTH  = gnd_pkg::COUNT_WIDTH_DEF,
    parameter int AMOUNT_WIDTH = gnd_pkg::AMOUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  gnd_pkg::req_word_t req,
    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  gnd_pkg::rsp_word_t rsp,
    output int                 fail_count,
    output int                 outstanding,
    output int                 stock_words,
    output int                 saturated_words,
    output int                 ignored_words,
    output int                 paid_words,
    output int                 refused_words
);
    import gnd_pkg::*;

    localparam longint unsigned COUNT_MAX   = (64'd1 << COUNT_WIDTH) - 1;
    localparam longint unsigned AMOUNT_MASK = (64'd1 << AMOUNT_WIDTH) - 1;

    // Slot positions of each note value, as the slot field numbers them.
    localparam int SLOT_ONE     = 0;
    localparam int SLOT_TWO     = 1;
    localparam int SLOT_FIVE    = 2;
    localparam int SLOT_TEN     = 3;
    localparam int SLOT_TWENTY  = 4;
    localparam int SLOT_FIFTY   = 5;
    localparam int SLOT_HUNDRED = 6;

    // Notes on hand in each slot, as the block should hold them.
    logic [COUNT_WIDTH-1:0] slot_stock [NUM_SLOTS];

    // Payouts still owed by the block, oldest first.
    rsp_word_t expected_payouts [$];

    // Works out the response to one request word and updates the stock.
    function automatic rsp_word_t predict_payout(req_word_t w);
        rsp_word_t       r;
        longint unsigned rest;
        longint unsigned q;
        longint unsigned sum;
        longint unsigned take [NUM_SLOTS];
        r = '0;
        if (w.func == FUNC_STOCK) begin
            stock_words++;
            if (w.slot < NUM_SLOTS) begin
                sum = slot_stock[w.slot];
                sum += w.note_count;
                if (sum > COUNT_MAX) begin
                    sum = COUNT_MAX;
                    saturated_words++;
                end
                slot_stock[w.slot] = COUNT_WIDTH'(sum);
                r.accepted = 1'b1;
            end else begin
                ignored_words++;
            end
            return r;
        end

        // Greedy pass from the largest note down.
        rest = w.amount & AMOUNT_MASK;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            q = rest / NOTE_VALUE[i];
            if (q > slot_stock[i])
                q = slot_stock[i];
            take[i] = q;
            rest -= q * NOTE_VALUE[i];
        end

        // Only a full payment touches the stock.
        if (rest == 0) begin
            paid_words++;
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_stock[i] = slot_stock[i] - COUNT_WIDTH'(take[i]);
            r.accepted     = 1'b1;
            r.take_hundred = TAKE_W'(take[SLOT_HUNDRED]);
            r.take_fifty   = TAKE_W'(take[SLOT_FIFTY]);
            r.take_twenty  = TAKE_W'(take[SLOT_TWENTY]);
            r.take_ten     = TAKE_W'(take[SLOT_TEN]);
            r.take_five    = TAKE_W'(take[SLOT_FIVE]);
            r.take_two     = TAKE_W'(take[SLOT_TWO]);
            r.take_one     = TAKE_W'(take[SLOT_ONE]);
        end else begin
            refused_words++;
        end
        return r;
    endfunction

    // Compares every field of a response word with the predicted one.
    task automatic compare_payout(input rsp_word_t want, input rsp_word_t got);
        logic [TAKE_W-1:0] want_f [8];
        logic [TAKE_W-1:0] got_f  [8];
        string             names  [8];
        names  = '{"accepted", "take_hundred", "take_fifty", "take_twenty",
                   "take_ten", "take_five", "take_two", "take_one"};
        want_f = '{TAKE_W'(want.accepted), want.take_hundred, want.take_fifty,
                   want.take_twenty, want.take_ten, want.take_five,
                   want.take_two, want.take_one};
        got_f  = '{TAKE_W'(got.accepted), got.take_hundred, got.take_fifty,
                   got.take_twenty, got.take_ten, got.take_five,
                   got.take_two, got.take_one};
        for (int i = 0; i < 8; i++) begin
            if (got_f[i] !== want_f[i]) begin
                fail_count++;
                $display("%0t: mismatch on %s, expected %0d, got %0d",
                         $time, names[i], want_f[i], got_f[i]);
            end
        end
    endtask

    // The response side is handled first, so a word that arrives with
    // nothing owed is never matched against a request of the same edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_stock[i] = '0;
            expected_payouts.delete();
            fail_count      = 0;
            stock_words     = 0;
            saturated_words = 0;
            ignored_words   = 0;
            paid_words      = 0;
            refused_words   = 0;
            outstanding    <= 0;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (expected_payouts.size() == 0) begin
                    fail_count++;
                    $display("%0t: response word with no request pending, expected none, got %h",
                             $time, rsp);
                end else begin
                    compare_payout(expected_payouts.pop_front(), rsp);
                end
            end
            if (req_valid && req_ready)
                expected_payouts = {expected_payouts, predict_payout(req)};
            outstanding <= expected_payouts.size();
        end
    end

endmodule

FILE: bench/tb_greedy_note_dispenser.sv
`timescale 1ns / 1ps

module tb_greedy_note_dispenser;
    import gnd_pkg::*;

    localparam int RANDOM_WORDS   = 2000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 600;
    localparam int DRAIN_CYCLES   = 150;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    rsp_word_t rsp;

    int sent;
    int burst_left;
    int fail_count;
    int outstanding;
    int stock_words;
    int saturated_words;
    int ignored_words;
    int paid_words;
    int refused_words;

    greedy_note_dispenser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    gnd_payout_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .stock_words     (stock_words),
        .saturated_words (saturated_words),
        .ignored_words   (ignored_words),
        .paid_words      (paid_words),
        .refused_words   (refused_words)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic req_word_t make_word(logic func, int slot, int count, int amount);
        req_word_t w;
        w.func       = func;
        w.slot       = SLOT_W'(slot);
        w.note_count = NOTE_COUNT_W'(count);
        w.amount     = AMOUNT_IN_W'(amount);
        return w;
    endfunction

    // Mostly small stock and modest amounts, so that both paid and refused
    // withdrawals keep turning up; the unused fields carry noise.
    function automatic req_word_t random_word();
        req_word_t w;
        int        pick;
        w.slot       = SLOT_W'($urandom_range(0, 7));
        w.note_count = NOTE_COUNT_W'($urandom);
        w.amount     = AMOUNT_IN_W'($urandom);
        pick         = $urandom_range(0, 99);
        if (pick < 35) begin
            w.func = FUNC_STOCK;
            if ($urandom_range(0, 15) != 0)
                w.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 85)
                w.note_count = NOTE_COUNT_W'($urandom_range(0, 40));
            else if (pick < 95)
                w.note_count = NOTE_COUNT_W'($urandom);
            else
                w.note_count = '1;
        end else begin
            w.func = FUNC_WITHDRAW;
            pick   = $urandom_range(0, 99);
            if (pick < 70)
                w.amount = AMOUNT_IN_W'($urandom_range(0, 600));
            else if (pick < 92)
                w.amount = AMOUNT_IN_W'($urandom_range(0, 20000));
            else
                w.amount = AMOUNT_IN_W'($urandom);
        end
        return w;
    endfunction

    // Offers one word, waits for it to be taken, then maybe pauses between bursts.
    task automatic send_word(input req_word_t w);
        int gap;
        req_valid <= 1'b1;
        req       <= w;
        do @(posedge clk); while (!req_ready);
        sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Receiver: stretches of always ready, mostly ready, coin flips and heavy stalling,
    // with one long hold-off once traffic is well under way.
    initial begin : receiver
        int mode;
        int span;
        bit held;
        held      = 1'b0;
        rsp_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
            if (!held && sent >= HOLD_AFTER) begin
                held = 1'b1;
                @(posedge clk);
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
        end
    end

    // Ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        sent       = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty dispenser: a zero amount is paid, anything else is refused.
        send_word(make_word(FUNC_WITHDRAW, 7, 'hFFFF, 0));
        send_word(make_word(FUNC_WITHDRAW, 0, 0, 1));

        // A few notes of every value, then the unused slot and saturation.
        for (int s = 0; s < NUM_SLOTS; s++)
            send_word(make_word(FUNC_STOCK, s, 3, 0));
        send_word(make_word(FUNC_STOCK, NUM_SLOTS, 'hFFFF, 'hFFFFFF));
        send_word(make_word(FUNC_STOCK, NUM_SLOTS - 1, 'hFFFF, 'hFFFFFF));
        send_word(make_word(FUNC_STOCK, NUM_SLOTS - 1, 1, 0));
        send_word(make_word(FUNC_STOCK, 3, 0, 'hFFFFFF));

        // One of each note, the largest amount, then a huge pile of hundreds.
        send_word(make_word(FUNC_WITHDRAW, 7, 'hFFFF, 188));
        send_word(make_word(FUNC_WITHDRAW, 0, 0, 'hFFFFFF));
        send_word(make_word(FUNC_WITHDRAW, 0, 0, 6553400));

        // Use up the ones so that an amount stays unpaid with notes on hand.
        send_word(make_word(FUNC_WITHDRAW, 5, 'h1234, 1));
        send_word(make_word(FUNC_WITHDRAW, 2, 'h00FF, 1));
        send_word(make_word(FUNC_WITHDRAW, 0, 0, 6));
        send_word(make_word(FUNC_WITHDRAW, 0, 0, 4));
        send_word(make_word(FUNC_WITHDRAW, 0, 0, 0));

        repeat (RANDOM_WORDS)
            send_word(random_word());
        req_valid <= 1'b0;

        // Let every owed response arrive, then watch for strays.
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d stock words (%0d saturated, %0d unused slot)",
                 sent, stock_words, saturated_words, ignored_words);
        $display("and %0d withdrawals (%0d paid, %0d refused), one %0d-cycle hold-off.",
                 paid_words + refused_words, paid_words, refused_words, LONG_HOLD);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
